/* hw/rtl/svptw_pkg.sv */
// Shared types, constants and helpers of the Sv39 page table walker.
// Depends on nothing; every other file of the walker imports it.
package svptw_pkg;

    localparam int VA_W     = 39;
    localparam int PPN_W    = 44;
    localparam int PA_W     = 56;
    localparam int ENTRY_W  = 64;
    localparam int LEVEL_W  = 2;
    localparam int VPN_W    = 9;
    localparam int PG_OFF_W = 12;

    localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_MID  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd0;

    // input item kind codes
    localparam logic KIND_TRANSLATE = 1'b0;
    localparam logic KIND_RESPONSE  = 1'b1;

    // result item kind codes
    localparam logic RES_READ = 1'b0;
    localparam logic RES_DONE = 1'b1;

    // page table entry bit positions
    localparam int PTE_V      = 0;
    localparam int PTE_R      = 1;
    localparam int PTE_W      = 2;
    localparam int PTE_PPN_LO = 10;

    typedef enum logic {
        OP_TRANSLATE,
        OP_ENTRY
    } op_t;

    // classified item held in the queue between front and back
    typedef struct packed {
        op_t               op;
        logic [VA_W-1:0]   vaddr;
        logic              bad;
        logic [PPN_W-1:0]  ppn;
    } svptw_item_t;

    typedef struct packed {
        logic               busy;
        logic [LEVEL_W-1:0] level;
    } svptw_back_status_t;

    function automatic logic [VPN_W-1:0] vpn_slice(input logic [VA_W-1:0] va,
                                                   input logic [LEVEL_W-1:0] lvl);
        logic [VPN_W-1:0] slice;
        case (lvl)
            LEVEL_TOP:  slice = va[PG_OFF_W+3*VPN_W-1 : PG_OFF_W+2*VPN_W];
            LEVEL_MID:  slice = va[PG_OFF_W+2*VPN_W-1 : PG_OFF_W+VPN_W];
            LEVEL_LEAF: slice = va[PG_OFF_W+VPN_W-1 : PG_OFF_W];
            default:    slice = '0;
        endcase
        return slice;
    endfunction

endpackage

/* hw/rtl/svptw_ifs.sv */
// Valid/ready channel interfaces of the Sv39 page table walker.
// Depends on svptw_pkg for field widths.
interface svptw_cmd_if import svptw_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [VA_W-1:0]      virt_addr;
    logic [ENTRY_W-1:0]   entry_word;

    modport source (output valid, output kind, output virt_addr, output entry_word,
                    input ready);
    modport sink   (input valid, input kind, input virt_addr, input entry_word,
                    output ready);
endinterface

interface svptw_rsp_if import svptw_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 kind_res;
    logic [PA_W-1:0]      read_addr;
    logic [PA_W-1:0]      phys_addr;
    logic                 fault;

    modport source (output valid, output kind_res, output read_addr, output phys_addr,
                    output fault, input ready);
    modport sink   (input valid, input kind_res, input read_addr, input phys_addr,
                    input fault, output ready);
endinterface

/* hw/rtl/svptw_front.sv */
// Front of the walker: accepts items, classifies them, checks entries
// and holds them in a two-entry queue. Depends on svptw_pkg, svptw_ifs.
module svptw_front import svptw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    svptw_cmd_if.sink    cmd,
    output svptw_item_t  head,
    output logic         head_valid,
    input  logic         pop
);

    svptw_item_t  q_mem [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    svptw_item_t  cls;
    logic         push;

    assign cmd.ready  = (count_reg != 2'd2);
    assign push       = cmd.valid && cmd.ready;
    assign head_valid = (count_reg != 2'd0);
    assign head       = q_mem[rd_ptr_reg];

    // classify and check the entry up front so the back has a short path
    always_comb
    begin
        cls.op    = (cmd.kind == KIND_TRANSLATE) ? OP_TRANSLATE : OP_ENTRY;
        cls.vaddr = cmd.virt_addr;
        cls.bad   = !cmd.entry_word[PTE_V] ||
                    (!cmd.entry_word[PTE_R] && cmd.entry_word[PTE_W]);
        cls.ppn   = cmd.entry_word[PTE_PPN_LO+PPN_W-1 : PTE_PPN_LO];
    end

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* hw/rtl/svptw_back.sv */
// Back of the walker: holds the walk state, carries out queued items and
// drives the registered result channel. Depends on svptw_pkg, svptw_ifs.
module svptw_back import svptw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [PPN_W-1:0]   root_ppn,
    input  svptw_item_t        head,
    input  logic               head_valid,
    output logic               pop,
    output svptw_back_status_t status,
    svptw_rsp_if.source        rsp
);

    logic               busy_reg, busy_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [VA_W-1:0]    vaddr_reg, vaddr_next;
    logic               out_valid_reg, out_valid_next;
    logic               kind_res_reg, kind_res_next;
    logic [PA_W-1:0]    read_addr_reg, read_addr_next;
    logic [PA_W-1:0]    phys_addr_reg, phys_addr_next;
    logic               fault_reg, fault_next;
    logic               has_res;
    logic [LEVEL_W-1:0] level_dn;

    // take the head whenever the output register is free or being drained
    assign pop = head_valid && (!out_valid_reg || rsp.ready);

    assign rsp.valid     = out_valid_reg;
    assign rsp.kind_res  = kind_res_reg;
    assign rsp.read_addr = read_addr_reg;
    assign rsp.phys_addr = phys_addr_reg;
    assign rsp.fault     = fault_reg;

    assign status.busy  = busy_reg;
    assign status.level = level_reg;

    assign level_dn = level_reg - 2'd1;

    always_comb
    begin
        busy_next      = busy_reg;
        level_next     = level_reg;
        vaddr_next     = vaddr_reg;
        kind_res_next  = kind_res_reg;
        read_addr_next = read_addr_reg;
        phys_addr_next = phys_addr_reg;
        fault_next     = fault_reg;
        has_res        = 1'b0;
        if (pop)
        begin
            case (head.op)
                OP_TRANSLATE:
                begin
                    if (!busy_reg)
                    begin
                        busy_next      = 1'b1;
                        level_next     = LEVEL_TOP;
                        vaddr_next     = head.vaddr;
                        has_res        = 1'b1;
                        kind_res_next  = RES_READ;
                        read_addr_next = {root_ppn, vpn_slice(head.vaddr, LEVEL_TOP), 3'b000};
                        phys_addr_next = '0;
                        fault_next     = 1'b0;
                    end
                end
                OP_ENTRY:
                begin
                    if (busy_reg)
                    begin
                        has_res = 1'b1;
                        if (head.bad)
                        begin
                            busy_next      = 1'b0;
                            level_next     = LEVEL_TOP;
                            kind_res_next  = RES_DONE;
                            read_addr_next = '0;
                            phys_addr_next = '0;
                            fault_next     = 1'b1;
                        end
                        else if (level_reg == LEVEL_LEAF)
                        begin
                            busy_next      = 1'b0;
                            level_next     = LEVEL_TOP;
                            kind_res_next  = RES_DONE;
                            read_addr_next = '0;
                            phys_addr_next = {head.ppn, vaddr_reg[PG_OFF_W-1:0]};
                            fault_next     = 1'b0;
                        end
                        else
                        begin
                            level_next     = level_dn;
                            kind_res_next  = RES_READ;
                            read_addr_next = {head.ppn, vpn_slice(vaddr_reg, level_dn), 3'b000};
                            phys_addr_next = '0;
                            fault_next     = 1'b0;
                        end
                    end
                end
                default:
                begin
                    has_res = 1'b0;
                end
            endcase
        end

        if (pop)
        begin
            out_valid_next = has_res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            level_reg     <= LEVEL_TOP;
            vaddr_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            level_reg     <= level_next;
            vaddr_reg     <= vaddr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_res_reg  <= kind_res_next;
        read_addr_reg <= read_addr_next;
        phys_addr_reg <= phys_addr_next;
        fault_reg     <= fault_next;
    end

endmodule

/* hw/rtl/sv39_page_table_walker.sv */
// Sv39 page table walker top level: root register, front, back, checks.
// Depends on svptw_pkg, svptw_ifs, svptw_front and svptw_back.
//
// The walker takes one item per cycle on cmd: a translate request (kind 0)
// or an entry word that memory returned (kind 1). A request while idle emits
// a read of the level-2 entry at {root_ppn, VPN[2], 3'b000}; each returned
// entry either faults (invalid, or writable but not readable), emits the
// read of the next level, or at level 0 finishes with
// {entry PPN, virt_addr[11:0]}. Requests while a walk is open and entries
// while idle are dropped without a result. The front checks the entry bits
// as the item is accepted and writes it into a two-entry queue; the back,
// which owns the walk state, pops the queue head when its output register
// is free or being drained and writes the result into that register. The
// queue lets input and output stall independently, so throughput is one
// item per cycle while rsp drains; a stalled rsp fills the queue and then
// holds cmd.ready low.
// Write root_ppn only while no item is in flight: a translate reads it when
// it reaches the back, and a walk in progress never reads it again.
// Superpages are not recognized.
module sv39_page_table_walker import svptw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              root_ppn_we,
    input  logic [PPN_W-1:0]  root_ppn_wdata,
    svptw_cmd_if.sink         cmd,
    svptw_rsp_if.source       rsp
);

    logic [PPN_W-1:0]    root_ppn_reg, root_ppn_next;
    svptw_item_t         head;
    logic                head_valid;
    logic                pop;
    svptw_back_status_t  back_status;

    // hold root_ppn until the next write
    assign root_ppn_next = root_ppn_we ? root_ppn_wdata : root_ppn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_ppn_reg <= '0;
        end
        else
        begin
            root_ppn_reg <= root_ppn_next;
        end
    end

    // accept, classify and queue
    svptw_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    // advance the walk and register the result
    svptw_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .root_ppn   (root_ppn_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .status     (back_status),
        .rsp        (rsp)
    );

`ifndef SYNTHESIS
    // an idle walker always sits at the top level
    assert property (@(posedge clk) disable iff (!rst_n)
        !back_status.busy |-> back_status.level == LEVEL_TOP)
        else $error("walker idle away from top level");

    // a finished walk waiting in the output register leaves the walker idle
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.kind_res == RES_DONE |-> !back_status.busy)
        else $error("walker busy behind a finish result");

    // a fault never carries an address
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.fault |->
            rsp.kind_res == RES_DONE && rsp.phys_addr == '0 && rsp.read_addr == '0)
        else $error("fault result carries an address");

    // a full queue means the back has work at its head
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> head_valid)
        else $error("input stalled with empty queue head");
`endif

endmodule
